// File: design/dhdr_pkg.sv
package dhdr_pkg;

    // Width of the signed target and applied duty words.
    localparam int DUTY_BITS = 16;
    // PWM compare value and duty register width.
    localparam int MAG_W     = 15;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DUTY_W = 16;
    localparam int MOTOR_W   = 2;

    // Set-duty shaping works one bit above the request so -max stays representable.
    localparam int SHAPE_W = IN_DUTY_W + 1;
    // Ramp math: room for applied +/- ramp_step and a negation.
    localparam int RAMP_W  = ((DUTY_BITS > MAG_W) ? DUTY_BITS : MAG_W) + 2;

    localparam logic [MAG_W-1:0] DUTY_LIMIT = MAG_W'((2 ** (DUTY_BITS - 1)) - 1);

    localparam logic [MOTOR_W-1:0] MTR_LEFT  = MOTOR_W'(0);
    localparam logic [MOTOR_W-1:0] MTR_RIGHT = MOTOR_W'(1);

    typedef logic signed [DUTY_BITS-1:0] duty_t;

    typedef enum logic [1:0] {
        KIND_SET_DUTY = 2'd0,
        KIND_TICK     = 2'd1,
        KIND_STOP     = 2'd2,
        KIND_ENABLE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RES_OK        = 2'd0,
        RES_BAD_MOTOR = 2'd1,
        RES_DISABLED  = 2'd2
    } result_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_DUTY       = 3'd0,
        REG_MIN_START_DUTY = 3'd1,
        REG_RAMP_STEP      = 3'd2,
        REG_LEFT_REVERSED  = 3'd3,
        REG_RIGHT_REVERSED = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [MAG_W-1:0] max_duty;
        logic [MAG_W-1:0] min_start_duty;
        logic [MAG_W-1:0] ramp_step;
        logic             left_reversed;
        logic             right_reversed;
    } cfg_t;

    // Per-motor command decoded from one request.
    typedef struct packed {
        logic  valid;
        logic  set_target;
        duty_t target;
        logic  tick;
        logic  stop;
        logic  brake;
    } motor_cmd_t;

    typedef struct packed {
        logic             in1;
        logic             in2;
        logic [MAG_W-1:0] magnitude;
    } motor_out_t;

endpackage

// File: design/dhdr_cfg_regs.sv
module dhdr_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [dhdr_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [dhdr_pkg::CFG_W-1:0]      cfg_wr_data,
    output dhdr_pkg::cfg_t                  cfg
);

    dhdr_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_duty       <= dhdr_pkg::MAG_W'(1000);
            cfg_reg.min_start_duty <= '0;
            cfg_reg.ramp_step      <= dhdr_pkg::MAG_W'(10);
            cfg_reg.left_reversed  <= 1'b0;
            cfg_reg.right_reversed <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                dhdr_pkg::REG_MAX_DUTY:       cfg_reg.max_duty       <= cfg_wr_data;
                dhdr_pkg::REG_MIN_START_DUTY: cfg_reg.min_start_duty <= cfg_wr_data;
                dhdr_pkg::REG_RAMP_STEP:      cfg_reg.ramp_step      <= cfg_wr_data;
                dhdr_pkg::REG_LEFT_REVERSED:  cfg_reg.left_reversed  <= cfg_wr_data[0];
                dhdr_pkg::REG_RIGHT_REVERSED: cfg_reg.right_reversed <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/dhdr_duty_shape.sv
module dhdr_duty_shape (
    input  logic signed [dhdr_pkg::IN_DUTY_W-1:0] duty,
    input  dhdr_pkg::cfg_t                        cfg,
    output dhdr_pkg::duty_t                       shaped
);

    localparam int W = dhdr_pkg::SHAPE_W;
    localparam logic signed [W-1:0] ZERO_W = '0;

    logic [dhdr_pkg::MAG_W-1:0] mx;
    logic [dhdr_pkg::MAG_W-1:0] mn;
    logic signed [W-1:0]        d_w;
    logic signed [W-1:0]        mx_w;
    logic signed [W-1:0]        mn_w;
    logic signed [W-1:0]        clamped;
    logic signed [W-1:0]        lifted;

    always_comb begin
        // limits saturate to the duty word range
        mx = (cfg.max_duty > dhdr_pkg::DUTY_LIMIT) ? dhdr_pkg::DUTY_LIMIT : cfg.max_duty;
        mn = (cfg.min_start_duty > dhdr_pkg::DUTY_LIMIT) ? dhdr_pkg::DUTY_LIMIT
                                                         : cfg.min_start_duty;
        d_w  = W'(duty);
        mx_w = signed'(W'(mx));
        mn_w = signed'(W'(mn));

        if (d_w > mx_w) begin
            clamped = mx_w;
        end else if (d_w < -mx_w) begin
            clamped = -mx_w;
        end else begin
            clamped = d_w;
        end

        // small non-zero values lift to the start duty, even past max
        if (clamped != ZERO_W && clamped < mn_w && clamped > -mn_w) begin
            lifted = (clamped > ZERO_W) ? mn_w : -mn_w;
        end else begin
            lifted = clamped;
        end

        shaped = dhdr_pkg::DUTY_BITS'(lifted);
    end

endmodule

// File: design/dhdr_motor.sv
module dhdr_motor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dhdr_pkg::motor_cmd_t          cmd,
    input  logic [dhdr_pkg::MAG_W-1:0]    ramp_step,
    input  logic                          reversed,
    output dhdr_pkg::motor_out_t          out_next
);

    localparam int W = dhdr_pkg::RAMP_W;
    localparam logic signed [W-1:0] ZERO_W = '0;

    dhdr_pkg::duty_t      target_reg;
    dhdr_pkg::duty_t      target_next;
    dhdr_pkg::duty_t      applied_reg;
    dhdr_pkg::duty_t      applied_next;
    dhdr_pkg::motor_out_t drive_reg;
    dhdr_pkg::motor_out_t drive_next;

    logic signed [W-1:0] a_w;
    logic signed [W-1:0] t_w;
    logic signed [W-1:0] s_w;
    logic signed [W-1:0] up_w;
    logic signed [W-1:0] dn_w;
    logic signed [W-1:0] ramped;
    logic signed [W-1:0] d_w;
    logic signed [W-1:0] abs_w;
    dhdr_pkg::motor_out_t tick_drive;

    always_comb begin
        a_w  = W'(applied_reg);
        t_w  = W'(target_reg);
        s_w  = signed'(W'(ramp_step));
        up_w = a_w + s_w;
        dn_w = a_w - s_w;

        // slew toward target, never overshoot
        if (a_w < t_w) begin
            ramped = (up_w > t_w) ? t_w : up_w;
        end else if (a_w > t_w) begin
            ramped = (dn_w < t_w) ? t_w : dn_w;
        end else begin
            ramped = a_w;
        end

        d_w = reversed ? -ramped : ramped;
        if (d_w > ZERO_W) begin
            tick_drive.in1 = 1'b1;
            tick_drive.in2 = 1'b0;
            abs_w          = d_w;
        end else if (d_w < ZERO_W) begin
            tick_drive.in1 = 1'b0;
            tick_drive.in2 = 1'b1;
            abs_w          = -d_w;
        end else begin
            tick_drive.in1 = 1'b0;
            tick_drive.in2 = 1'b0;
            abs_w          = '0;
        end
        tick_drive.magnitude = dhdr_pkg::MAG_W'(abs_w);
    end

    always_comb begin
        target_next  = target_reg;
        applied_next = applied_reg;
        drive_next   = drive_reg;
        if (cmd.valid) begin
            if (cmd.stop) begin
                target_next          = '0;
                applied_next         = '0;
                drive_next.in1       = cmd.brake;
                drive_next.in2       = cmd.brake;
                drive_next.magnitude = '0;
            end else if (cmd.set_target) begin
                target_next = cmd.target;
            end else if (cmd.tick) begin
                // applied duty kept before reversal
                applied_next = dhdr_pkg::DUTY_BITS'(ramped);
                drive_next   = tick_drive;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg  <= '0;
            applied_reg <= '0;
            drive_reg   <= '0;
        end else begin
            target_reg  <= target_next;
            applied_reg <= applied_next;
            drive_reg   <= drive_next;
        end
    end

    assign out_next = drive_next;

endmodule

// File: design/dual_hbridge_duty_ramp_top.sv
// Dual H-bridge duty ramp. Each request carries a kind: set duty (clamped to
// +-max_duty, small non-zero values lifted to +-min_start_duty, stored as the
// motor's target), ramp tick (both applied duties step toward their targets
// by at most ramp_step and drive the pins and PWM magnitude, direction
// inverted for a reversed motor), stop one motor (coast or brake until the
// next tick) or enable/disable (disable coasts both motors and drops
// standby). Every request returns exactly one result: a status and the pin
// levels, magnitudes and standby level after the request took effect. The
// block takes one request per clock while m_ready keeps the result register
// draining. Each request is first held in the input register, then moves
// through the decode, shaping and ramp logic into the result register,
// which drives m_valid. While a result waits on m_ready the input register
// still takes one more request; s_ready then stays low until the result
// drains. Configuration writes are registered and are meant for an idle
// block; indexes beyond the five registers are ignored.
module dual_hbridge_duty_ramp_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_wr_en,
    input  logic [dhdr_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  logic [dhdr_pkg::CFG_W-1:0]           cfg_wr_data,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_kind,
    input  logic [dhdr_pkg::MOTOR_W-1:0]         s_motor,
    input  logic signed [dhdr_pkg::IN_DUTY_W-1:0] s_duty,
    input  logic                                 s_brake,
    input  logic                                 s_enable_flag,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_status,
    output logic                                 m_left_in1,
    output logic                                 m_left_in2,
    output logic [dhdr_pkg::MAG_W-1:0]           m_left_magnitude,
    output logic                                 m_right_in1,
    output logic                                 m_right_in2,
    output logic [dhdr_pkg::MAG_W-1:0]           m_right_magnitude,
    output logic                                 m_standby_high
);

    dhdr_pkg::cfg_t cfg;

    // input register
    logic                                  in_valid_reg;
    dhdr_pkg::kind_t                       kind_reg;
    logic [dhdr_pkg::MOTOR_W-1:0]          motor_reg;
    logic signed [dhdr_pkg::IN_DUTY_W-1:0] duty_reg;
    logic                                  brake_reg;
    logic                                  enable_flag_reg;

    // shared control state
    logic enabled_reg;
    logic enabled_next;

    // result register
    logic                   m_valid_reg;
    dhdr_pkg::result_code_t status_reg;
    dhdr_pkg::result_code_t status_next;
    dhdr_pkg::motor_out_t   left_reg;
    dhdr_pkg::motor_out_t   right_reg;
    logic                   standby_reg;

    logic                   advance;
    logic                   motor_ok;
    dhdr_pkg::duty_t        shaped;
    dhdr_pkg::motor_cmd_t   left_cmd;
    dhdr_pkg::motor_cmd_t   right_cmd;
    dhdr_pkg::motor_out_t   left_next;
    dhdr_pkg::motor_out_t   right_next;

    // request moves to the result register when that register is free or drains
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    dhdr_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg        <= dhdr_pkg::kind_t'(s_kind);
            motor_reg       <= s_motor;
            duty_reg        <= s_duty;
            brake_reg       <= s_brake;
            enable_flag_reg <= s_enable_flag;
        end
    end

    dhdr_duty_shape u_shape (
        .duty   (duty_reg),
        .cfg    (cfg),
        .shaped (shaped)
    );

    // Decode one request into status, per-motor commands and enable state.
    // Invalid motor is checked ahead of the disabled check; tick and stop
    // act even while disabled.
    always_comb begin
        motor_ok     = (motor_reg == dhdr_pkg::MTR_LEFT) ||
                       (motor_reg == dhdr_pkg::MTR_RIGHT);
        status_next  = dhdr_pkg::RES_OK;
        enabled_next = enabled_reg;
        left_cmd     = '0;
        right_cmd    = '0;
        left_cmd.valid   = advance;
        right_cmd.valid  = advance;
        left_cmd.target  = shaped;
        right_cmd.target = shaped;

        unique case (kind_reg)
            dhdr_pkg::KIND_SET_DUTY: begin
                if (!motor_ok) begin
                    status_next = dhdr_pkg::RES_BAD_MOTOR;
                end else if (!enabled_reg) begin
                    status_next = dhdr_pkg::RES_DISABLED;
                end else begin
                    left_cmd.set_target  = (motor_reg == dhdr_pkg::MTR_LEFT);
                    right_cmd.set_target = (motor_reg == dhdr_pkg::MTR_RIGHT);
                end
            end
            dhdr_pkg::KIND_TICK: begin
                left_cmd.tick  = 1'b1;
                right_cmd.tick = 1'b1;
            end
            dhdr_pkg::KIND_STOP: begin
                if (!motor_ok) begin
                    status_next = dhdr_pkg::RES_BAD_MOTOR;
                end
                left_cmd.stop   = (motor_reg == dhdr_pkg::MTR_LEFT);
                right_cmd.stop  = (motor_reg == dhdr_pkg::MTR_RIGHT);
                left_cmd.brake  = brake_reg;
                right_cmd.brake = brake_reg;
            end
            dhdr_pkg::KIND_ENABLE: begin
                enabled_next = enable_flag_reg;
                // emergency stop: both motors coast
                if (!enable_flag_reg) begin
                    left_cmd.stop  = 1'b1;
                    right_cmd.stop = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    dhdr_motor u_left (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (left_cmd),
        .ramp_step (cfg.ramp_step),
        .reversed  (cfg.left_reversed),
        .out_next  (left_next)
    );

    dhdr_motor u_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (right_cmd),
        .ramp_step (cfg.ramp_step),
        .reversed  (cfg.right_reversed),
        .out_next  (right_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                enabled_reg <= enabled_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: state as left by the request
    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg  <= status_next;
            left_reg    <= left_next;
            right_reg   <= right_next;
            standby_reg <= enabled_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = status_reg;
    assign m_left_in1        = left_reg.in1;
    assign m_left_in2        = left_reg.in2;
    assign m_left_magnitude  = left_reg.magnitude;
    assign m_right_in1       = right_reg.in1;
    assign m_right_in2       = right_reg.in2;
    assign m_right_magnitude = right_reg.magnitude;
    assign m_standby_high    = standby_reg;

endmodule
